FILE: rtl/mpsm_pkg.sv
// mpsm_pkg: shared types and constants for the multi-pattern string matcher
// depends on nothing; imported by every module of the block
package mpsm_pkg;

    localparam int FUNC_W  = 2;
    localparam int SLOT_W  = 3;
    localparam int CIDX_W  = 4;
    localparam int BYTE_W  = 8;
    localparam int PLEN_W  = 5;
    localparam int START_W = 16;
    localparam int MLEN_W  = 5;
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_WRITE  = 2'd0,
        FUNC_LENGTH = 2'd1,
        FUNC_TEXT   = 2'd2,
        FUNC_START  = 2'd3
    } t_func;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

endpackage

FILE: rtl/multi_pattern_string_matcher.sv
// a text byte's hits pass via the hit queue and back end to the output register
// throughput: one word per cycle while o_stall is low; a byte with k matches
// yields k results; the hit queue lets further bytes in meanwhile until it fills
// a length word waits until all earlier matches have been handed out
// reset (synchronous, active low) clears patterns, lengths, text window and position
module multi_pattern_string_matcher #(
    parameter int MAX_PATTERNS = 8,
    parameter int MAX_LEN      = 16,
    parameter int MAX_TEXT     = 65536
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [mpsm_pkg::FUNC_W-1:0]   i_func,
    input  logic [mpsm_pkg::SLOT_W-1:0]   i_slot,
    input  logic [mpsm_pkg::CIDX_W-1:0]   i_char_index,
    input  logic [mpsm_pkg::BYTE_W-1:0]   i_byte_value,
    input  logic [mpsm_pkg::PLEN_W-1:0]   i_pattern_length,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [mpsm_pkg::START_W-1:0]  o_start_index,
    output logic [mpsm_pkg::MLEN_W-1:0]   o_match_length,
    output logic [mpsm_pkg::SLOT_W-1:0]   o_match_slot,
    output logic                          o_last
);
    import mpsm_pkg::*;

    localparam int LEN_W   = $clog2(MAX_LEN + 1);
    localparam int ENTRY_W = START_W + MAX_PATTERNS;

    t_q_status                 q_stat;
    logic                      q_push;
    logic [ENTRY_W-1:0]        q_push_data;
    logic                      q_pop;
    logic [ENTRY_W-1:0]        q_pop_data;
    logic                      back_busy;
    logic [MAX_PATTERNS*LEN_W-1:0] lengths;

    mpsm_front #(
        .MAX_PATTERNS (MAX_PATTERNS),
        .MAX_LEN      (MAX_LEN),
        .MAX_TEXT     (MAX_TEXT)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_func           (i_func),
        .i_slot           (i_slot),
        .i_char_index     (i_char_index),
        .i_byte_value     (i_byte_value),
        .i_pattern_length (i_pattern_length),
        .i_q_stat         (q_stat),
        .i_back_busy      (back_busy),
        .o_push           (q_push),
        .o_push_data      (q_push_data),
        .o_lengths        (lengths)
    );

    mpsm_queue #(
        .DATA_W (ENTRY_W)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_push_data),
        .i_pop       (q_pop),
        .o_pop_data  (q_pop_data),
        .o_stat      (q_stat)
    );

    mpsm_back #(
        .MAX_PATTERNS (MAX_PATTERNS),
        .MAX_LEN      (MAX_LEN)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_stat       (q_stat),
        .i_q_data       (q_pop_data),
        .o_pop          (q_pop),
        .o_busy         (back_busy),
        .i_lengths      (lengths),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_start_index  (o_start_index),
        .o_match_length (o_match_length),
        .o_match_slot   (o_match_slot),
        .o_last         (o_last)
    );

endmodule

FILE: rtl/mpsm_front.sv
// mpsm_front: input side, holds pattern table, slot lengths and text window
// compares every slot against the window and pushes hit masks; uses mpsm_pkg
module mpsm_front #(
    parameter int MAX_PATTERNS = 8,
    parameter int MAX_LEN      = 16,
    parameter int MAX_TEXT     = 65536,
    localparam int LEN_W       = $clog2(MAX_LEN + 1),
    localparam int ENTRY_W     = mpsm_pkg::START_W + MAX_PATTERNS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [mpsm_pkg::FUNC_W-1:0]   i_func,
    input  logic [mpsm_pkg::SLOT_W-1:0]   i_slot,
    input  logic [mpsm_pkg::CIDX_W-1:0]   i_char_index,
    input  logic [mpsm_pkg::BYTE_W-1:0]   i_byte_value,
    input  logic [mpsm_pkg::PLEN_W-1:0]   i_pattern_length,
    input  mpsm_pkg::t_q_status           i_q_stat,
    input  logic                          i_back_busy,
    output logic                          o_push,
    output logic [ENTRY_W-1:0]            o_push_data,
    output logic [MAX_PATTERNS*LEN_W-1:0] o_lengths
);
    import mpsm_pkg::*;

    localparam int WIN_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int SEEN_W = $clog2(MAX_TEXT + 1);
    localparam int CMP_W  = ((LEN_W > SEEN_W) ? LEN_W : SEEN_W) + 1;

    logic [BYTE_W-1:0] r_pat [MAX_PATTERNS][MAX_LEN];
    logic [LEN_W-1:0]  r_len [MAX_PATTERNS];
    logic [BYTE_W-1:0] r_window [MAX_LEN];
    logic [SEEN_W-1:0] r_seen;

    logic [BYTE_W-1:0]       w_shift [MAX_LEN];
    logic [MAX_PATTERNS-1:0] w_hit;
    logic [LEN_W-1:0]        w_sat_len;
    logic                    w_overflow;
    logic                    w_accept;
    t_func                   w_func;

    assign w_func     = t_func'(i_func);
    assign w_overflow = (r_seen >= SEEN_W'(MAX_TEXT));
    assign w_sat_len  = (int'(i_pattern_length) > MAX_LEN) ? LEN_W'(MAX_LEN)
                                                           : LEN_W'(i_pattern_length);

    assign o_stall  = i_valid && (((w_func == FUNC_TEXT) && i_q_stat.full) ||
                                  ((w_func == FUNC_LENGTH) &&
                                   (!i_q_stat.empty || i_back_busy)));
    assign w_accept = i_valid && !o_stall;

    always_comb begin
        w_shift[0] = i_byte_value;
        for (int j = 1; j < MAX_LEN; j++) begin
            w_shift[j] = r_window[j-1];
        end
    end

    // pattern byte i lines up with the byte len-1-i places back
    always_comb begin
        logic             ok;
        logic [LEN_W-1:0] idx;
        for (int s = 0; s < MAX_PATTERNS; s++) begin
            ok = 1'b1;
            for (int i = 0; i < MAX_LEN; i++) begin
                idx = r_len[s] - LEN_W'(1) - LEN_W'(i);
                if ((LEN_W'(i) < r_len[s]) && (r_pat[s][i] != w_shift[idx[WIN_W-1:0]])) begin
                    ok = 1'b0;
                end
            end
            w_hit[s] = ok && (r_len[s] != '0) &&
                       (CMP_W'(r_len[s]) <= CMP_W'(r_seen) + CMP_W'(1));
        end
    end

    always_comb begin
        for (int s = 0; s < MAX_PATTERNS; s++) begin
            o_lengths[s*LEN_W +: LEN_W] = r_len[s];
        end
    end

    assign o_push      = w_accept && (w_func == FUNC_TEXT) && !w_overflow && (|w_hit);
    assign o_push_data = {START_W'(r_seen), w_hit};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
            for (int j = 0; j < MAX_LEN; j++) begin
                r_window[j] <= '0;
            end
            for (int s = 0; s < MAX_PATTERNS; s++) begin
                r_len[s] <= '0;
                for (int c = 0; c < MAX_LEN; c++) begin
                    r_pat[s][c] <= '0;
                end
            end
        end else if (w_accept) begin
            unique case (w_func)
                FUNC_WRITE: begin
                    for (int s = 0; s < MAX_PATTERNS; s++) begin
                        for (int c = 0; c < MAX_LEN; c++) begin
                            if ((int'(i_slot) == s) && (int'(i_char_index) == c)) begin
                                r_pat[s][c] <= i_byte_value;
                            end
                        end
                    end
                end
                FUNC_LENGTH: begin
                    for (int s = 0; s < MAX_PATTERNS; s++) begin
                        if (int'(i_slot) == s) begin
                            r_len[s] <= w_sat_len;
                        end
                    end
                end
                FUNC_TEXT: begin
                    if (!w_overflow) begin
                        r_seen <= r_seen + SEEN_W'(1);
                        for (int j = 0; j < MAX_LEN; j++) begin
                            r_window[j] <= w_shift[j];
                        end
                    end
                end
                FUNC_START: begin
                    r_seen <= '0;
                    for (int j = 0; j < MAX_LEN; j++) begin
                        r_window[j] <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

FILE: rtl/mpsm_queue.sv
// mpsm_queue: small fifo of hit words between front and back
// depth from mpsm_pkg
module mpsm_queue #(
    parameter int DATA_W = 24
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  logic [DATA_W-1:0]     i_push_data,
    input  logic                  i_pop,
    output logic [DATA_W-1:0]     o_pop_data,
    output mpsm_pkg::t_q_status   o_stat
);
    import mpsm_pkg::*;

    logic [DATA_W-1:0]  r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;

    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_pop_data   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + Q_CNT_W'(1);
                2'b01:   r_count <= r_count - Q_CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: rtl/mpsm_back.sv
// mpsm_back: output side, turns each hit word into one result per slot
// lowest slot first, with an output register; uses mpsm_pkg
module mpsm_back #(
    parameter int MAX_PATTERNS = 8,
    parameter int MAX_LEN      = 16,
    localparam int LEN_W       = $clog2(MAX_LEN + 1),
    localparam int ENTRY_W     = mpsm_pkg::START_W + MAX_PATTERNS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  mpsm_pkg::t_q_status            i_q_stat,
    input  logic [ENTRY_W-1:0]             i_q_data,
    output logic                           o_pop,
    output logic                           o_busy,
    input  logic [MAX_PATTERNS*LEN_W-1:0]  i_lengths,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [mpsm_pkg::START_W-1:0]   o_start_index,
    output logic [mpsm_pkg::MLEN_W-1:0]    o_match_length,
    output logic [mpsm_pkg::SLOT_W-1:0]    o_match_slot,
    output logic                           o_last
);
    import mpsm_pkg::*;

    localparam int SEL_W = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;

    logic                    r_busy;
    logic [MAX_PATTERNS-1:0] r_mask;
    logic [START_W-1:0]      r_pos;
    logic                    r_valid;
    logic [START_W-1:0]      r_start;
    logic [MLEN_W-1:0]       r_mlen;
    logic [SLOT_W-1:0]       r_slot;
    logic                    r_last;

    logic                    w_advance;
    logic                    w_emit;
    logic                    w_load;
    logic [MAX_PATTERNS-1:0] w_one;
    logic [MAX_PATTERNS-1:0] w_rest;
    logic [SEL_W-1:0]        w_sel;
    logic [LEN_W-1:0]        w_len;

    assign w_advance = !r_valid || !i_stall;
    assign w_emit    = w_advance && r_busy;
    assign w_one     = r_mask & (~r_mask + MAX_PATTERNS'(1));
    assign w_rest    = r_mask & ~w_one;
    assign w_load    = !i_q_stat.empty && (!r_busy || (w_emit && (w_rest == '0)));
    assign o_pop     = w_load;
    assign o_busy    = r_busy;

    always_comb begin
        w_sel = '0;
        w_len = '0;
        for (int s = 0; s < MAX_PATTERNS; s++) begin
            if (w_one[s]) begin
                w_sel = SEL_W'(s);
                w_len = i_lengths[s*LEN_W +: LEN_W];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (w_advance) begin
                r_valid <= r_busy;
            end
            if (w_emit) begin
                r_start <= r_pos + START_W'(1) - START_W'(w_len);
                r_mlen  <= MLEN_W'(w_len);
                r_slot  <= SLOT_W'(w_sel);
                r_last  <= (w_rest == '0);
            end
            if (w_load) begin
                r_busy <= 1'b1;
                r_mask <= i_q_data[MAX_PATTERNS-1:0];
                r_pos  <= i_q_data[ENTRY_W-1 -: START_W];
            end else if (w_emit) begin
                r_mask <= w_rest;
                if (w_rest == '0) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_valid        = r_valid;
    assign o_start_index  = r_start;
    assign o_match_length = r_mlen;
    assign o_match_slot   = r_slot;
    assign o_last         = r_last;

endmodule

FILE: verif/tb_multi_pattern_string_matcher.sv
// self-checking testbench for multi_pattern_string_matcher: loads patterns, streams
// text words and checks every reported match against a behavioral predictor
// depends on mpsm_pkg and the multi_pattern_string_matcher rtl
module tb_multi_pattern_string_matcher;
    import mpsm_pkg::*;

    localparam int PAT_SLOTS    = 8;
    localparam int PAT_LEN      = 16;
    localparam int TEXT_LIMIT   = 65536;
    localparam int RANDOM_WORDS = 420;
    localparam int DRAIN_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 1500000;
    localparam int PRINT_LIMIT  = 200;

    typedef struct packed {
        logic [START_W-1:0] start_index;
        logic [MLEN_W-1:0]  match_length;
        logic [SLOT_W-1:0]  match_slot;
        logic               last;
    } t_hit;

    class match_scoreboard;
        logic [BYTE_W-1:0] window [PAT_LEN];
        int unsigned       seen;
        logic [BYTE_W-1:0] pattern_bytes [PAT_SLOTS][PAT_LEN];
        logic [PLEN_W-1:0] slot_len [PAT_SLOTS];
        t_hit              awaited [$];
        int                mismatches;

        function new();
            seen = 0;
            mismatches = 0;
            foreach (window[j]) window[j] = '0;
            foreach (pattern_bytes[s, j]) pattern_bytes[s][j] = '0;
            foreach (slot_len[s]) slot_len[s] = '0;
        endfunction

        function void note_word(t_func f, logic [SLOT_W-1:0] sl, logic [CIDX_W-1:0] ci,
                                logic [BYTE_W-1:0] b, logic [PLEN_W-1:0] pl);
            t_hit        h;
            int          first;
            int          len;
            bit          hit;
            int unsigned pos;
            case (f)
                FUNC_WRITE: begin
                    if (sl < PAT_SLOTS && ci < PAT_LEN) pattern_bytes[sl][ci] = b;
                end
                FUNC_LENGTH: begin
                    if (sl < PAT_SLOTS) slot_len[sl] = (pl > PAT_LEN) ? PLEN_W'(PAT_LEN) : pl;
                end
                FUNC_START: begin
                    seen = 0;
                    foreach (window[j]) window[j] = '0;
                end
                FUNC_TEXT: begin
                    if (seen < TEXT_LIMIT) begin
                        for (int j = PAT_LEN - 1; j > 0; j--) window[j] = window[j-1];
                        window[0] = b;
                        pos = seen;
                        seen++;
                        first = awaited.size();
                        for (int s = 0; s < PAT_SLOTS; s++) begin
                            len = slot_len[s];
                            if (len == 0 || len > PAT_LEN || len > seen) continue;
                            hit = 1'b1;
                            for (int i = 0; i < len; i++)
                                if (pattern_bytes[s][i] != window[len-1-i]) hit = 1'b0;
                            if (!hit) continue;
                            h.start_index  = START_W'(pos + 1 - len);
                            h.match_length = MLEN_W'(len);
                            h.match_slot   = SLOT_W'(s);
                            h.last         = 1'b0;
                            awaited.push_back(h);
                        end
                        if (awaited.size() > first) awaited[awaited.size()-1].last = 1'b1;
                    end
                end
            endcase
        endfunction

        task report(string what);
            if (mismatches < PRINT_LIMIT) $display("mismatch at %0t: %s", $realtime, what);
            mismatches++;
        endtask

        task check_result(logic [START_W-1:0] st, logic [MLEN_W-1:0] ln,
                          logic [SLOT_W-1:0] sl, logic lst);
            t_hit want;
            if (awaited.size() == 0) begin
                report($sformatf("unexpected match start %0d length %0d slot %0d", st, ln, sl));
                return;
            end
            want = awaited.pop_front();
            if (st !== want.start_index)
                report($sformatf("start_index %0d, want %0d", st, want.start_index));
            if (ln !== want.match_length)
                report($sformatf("match_length %0d, want %0d", ln, want.match_length));
            if (sl !== want.match_slot)
                report($sformatf("match_slot %0d, want %0d", sl, want.match_slot));
            if (lst !== want.last)
                report($sformatf("last %0b, want %0b", lst, want.last));
        endtask
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    logic [FUNC_W-1:0]   i_func;
    logic [SLOT_W-1:0]   i_slot;
    logic [CIDX_W-1:0]   i_char_index;
    logic [BYTE_W-1:0]   i_byte_value;
    logic [PLEN_W-1:0]   i_pattern_length;
    logic                o_valid;
    logic                i_stall;
    logic [START_W-1:0]  o_start_index;
    logic [MLEN_W-1:0]   o_match_length;
    logic [SLOT_W-1:0]   o_match_slot;
    logic                o_last;

    match_scoreboard sb;
    int              words_sent;
    int              cycles = 0;
    int              stall_left = 0;
    bit              in_calm = 1'b0;
    bit              stall_calm = 1'b0;
    logic [BYTE_W-1:0] sym_base = '0;
    int              sym_span = 0;

    multi_pattern_string_matcher #(
        .MAX_PATTERNS(PAT_SLOTS),
        .MAX_LEN(PAT_LEN),
        .MAX_TEXT(TEXT_LIMIT)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_func(i_func),
        .i_slot(i_slot),
        .i_char_index(i_char_index),
        .i_byte_value(i_byte_value),
        .i_pattern_length(i_pattern_length),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_start_index(o_start_index),
        .o_match_length(o_match_length),
        .o_match_slot(o_match_slot),
        .o_last(o_last)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // output back-pressure: short bursts, rare long holds
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end else if (!stall_calm && $urandom_range(0, 99) < 25) begin
            i_stall <= 1'b1;
            stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                      : $urandom_range(0, 2);
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall)
                sb.note_word(t_func'(i_func), i_slot, i_char_index, i_byte_value,
                             i_pattern_length);
            if (o_valid && !i_stall)
                sb.check_result(o_start_index, o_match_length, o_match_slot, o_last);
        end
    end

    task automatic send_word(input t_func f, input logic [SLOT_W-1:0] sl,
                             input logic [CIDX_W-1:0] ci, input logic [BYTE_W-1:0] b,
                             input logic [PLEN_W-1:0] pl);
        int gap;
        int r;
        gap = 0;
        r = $urandom_range(0, 99);
        if (!in_calm) begin
            if (r >= 97) gap = $urandom_range(15, 40);
            else if (r >= 88) gap = $urandom_range(4, 10);
            else if (r >= 60) gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_func           <= f;
        i_slot           <= sl;
        i_char_index     <= ci;
        i_byte_value     <= b;
        i_pattern_length <= pl;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        words_sent++;
    endtask

    task automatic send_text(input logic [BYTE_W-1:0] b);
        send_word(FUNC_TEXT, SLOT_W'($urandom_range(0, 7)), CIDX_W'($urandom_range(0, 15)),
                  b, PLEN_W'($urandom_range(0, 31)));
    endtask

    task automatic send_start();
        send_word(FUNC_START, SLOT_W'($urandom_range(0, 7)), CIDX_W'($urandom_range(0, 15)),
                  BYTE_W'($urandom_range(0, 255)), PLEN_W'($urandom_range(0, 31)));
    endtask

    function automatic logic [BYTE_W-1:0] sym();
        return sym_base + BYTE_W'($urandom_range(0, sym_span));
    endfunction

    initial begin
        int k;
        int c;
        int r;
        int sl;
        int plen;
        int nbytes;
        sb = new();
        i_rst_n          <= 1'b0;
        i_valid          <= 1'b0;
        i_func           <= '0;
        i_slot           <= '0;
        i_char_index     <= '0;
        i_byte_value     <= '0;
        i_pattern_length <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: duplicates, unwritten bytes, saturated length, short text, disable
        send_text(8'h00);
        send_word(FUNC_WRITE, 3'd0, 4'd0, 8'h61, 5'd0);
        send_word(FUNC_WRITE, 3'd0, 4'd1, 8'h62, 5'd31);
        send_word(FUNC_WRITE, 3'd1, 4'd0, 8'h61, 5'd0);
        send_word(FUNC_WRITE, 3'd1, 4'd1, 8'h62, 5'd16);
        send_word(FUNC_LENGTH, 3'd0, 4'd0, 8'h00, 5'd2);
        send_word(FUNC_LENGTH, 3'd1, 4'd15, 8'hff, 5'd2);
        send_word(FUNC_LENGTH, 3'd3, 4'd0, 8'h00, 5'd3);
        send_word(FUNC_WRITE, 3'd7, 4'd15, 8'hff, 5'd0);
        send_word(FUNC_LENGTH, 3'd7, 4'd0, 8'h00, 5'd31);
        send_start();
        send_text(8'h00);
        send_text(8'h00);
        send_text(8'h00);
        send_text(8'h61);
        send_text(8'h62);
        send_word(FUNC_LENGTH, 3'd1, 4'd0, 8'h00, 5'd0);
        send_text(8'h61);
        send_text(8'h62);
        send_word(FUNC_LENGTH, 3'd5, 4'd0, 8'h00, 5'd1);
        send_text(8'h00);
        send_text(8'hff);
        send_start();

        words_sent = 0;
        while (words_sent < RANDOM_WORDS) begin
            in_calm = ($urandom_range(0, 4) == 0);
            stall_calm = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 9) < 7) begin
                // reload some slots from a narrow alphabet, then text that hits them
                sym_base = BYTE_W'($urandom_range(0, 255));
                sym_span = $urandom_range(0, 3);
                repeat ($urandom_range(1, 3)) begin
                    sl = $urandom_range(0, PAT_SLOTS - 1);
                    r = $urandom_range(0, 9);
                    if (r == 0) plen = 0;
                    else if (r == 1) plen = $urandom_range(17, 31);
                    else if (r < 4) plen = PAT_LEN;
                    else plen = $urandom_range(1, 6);
                    for (c = 0; c < plen && c < PAT_LEN; c++)
                        send_word(FUNC_WRITE, SLOT_W'(sl), CIDX_W'(c), sym(),
                                  PLEN_W'($urandom_range(0, 31)));
                    send_word(FUNC_LENGTH, SLOT_W'(sl), CIDX_W'($urandom_range(0, 15)),
                              BYTE_W'($urandom_range(0, 255)), PLEN_W'(plen));
                end
                if ($urandom_range(0, 1)) send_start();
                nbytes = $urandom_range(8, 40);
                k = 0;
                while (k < nbytes) begin
                    sl = $urandom_range(0, PAT_SLOTS - 1);
                    if ($urandom_range(0, 4) == 0 && sb.slot_len[sl] != 0) begin
                        for (c = 0; c < sb.slot_len[sl]; c++)
                            send_text(sb.pattern_bytes[sl][c]);
                        k += sb.slot_len[sl];
                    end else begin
                        send_text(sym());
                        k++;
                    end
                end
            end else begin
                repeat ($urandom_range(3, 12))
                    send_word(t_func'($urandom_range(0, 3)), SLOT_W'($urandom_range(0, 7)),
                              CIDX_W'($urandom_range(0, 15)), BYTE_W'($urandom_range(0, 255)),
                              PLEN_W'($urandom_range(0, 31)));
            end
        end
        i_valid <= 1'b0;

        do @(posedge i_clk); while (sb.awaited.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

FILE: multi_pattern_string_matcher.f
rtl/mpsm_pkg.sv
rtl/mpsm_front.sv
rtl/mpsm_queue.sv
rtl/mpsm_back.sv
rtl/multi_pattern_string_matcher.sv
verif/tb_multi_pattern_string_matcher.sv
